### rtl/bce_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and elaboration-time ln(1+x) table builder for the
// binary cross-entropy block. No dependencies.
package bce_pkg;

    localparam int LOG_TABLE_DEPTH_DEF = 256;
    localparam int DIV_STEPS           = 32;

    localparam logic [16:0] ONE_Q16 = 17'd65536;
    localparam logic [47:0] SUM_MAX = 48'hFFFF_FFFF_FFFF;

    // Command bundle from controller to datapath.
    typedef struct packed {
        logic start;     // input request accepted
        logic prep;      // form denominator, seed divider
        logic div_step;  // one radix-2 quotient bit
        logic l1;        // log: normalise and index
        logic l2;        // log: table read
        logic l3;        // log: interpolation product
        logic l4;        // log: combine with exponent
        logic l5;        // log: weight and accumulate
        logic lq;        // log operand is 1-p rather than p
        logic finish;    // saturate, accumulate, load output register
    } bce_cmd_t;

    typedef struct packed {
        logic out_free;
    } bce_stat_t;

    // Unsigned 64-bit restoring division, evaluated at elaboration only.
    function automatic logic [63:0] udiv64(input logic [63:0] n, input logic [63:0] d);
        logic [64:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--)
        begin
            rem = {rem[63:0], n[b]};
            if (rem >= {1'b0, d})
            begin
                rem    = rem - {1'b0, d};
                quo[b] = 1'b1;
            end
        end
        return quo;
    endfunction

    // ln(1+y) in Q0.30 by the atanh series, truncating steps.
    function automatic logic [63:0] ln1p_q30(input logic [63:0] y);
        logic [63:0] z;
        logic [63:0] z2;
        logic [63:0] term;
        logic [63:0] acc;
        z    = udiv64(y << 30, (64'd2 << 30) + y);
        z2   = (z * z) >> 30;
        term = z;
        acc  = 64'd0;
        for (int k = 1; k < 60; k += 2)
        begin
            acc  = acc + udiv64(term, 64'(k));
            term = (term * z2) >> 30;
        end
        return acc << 1;
    endfunction

    function automatic logic [23:0] q30_to_q24(input logic [63:0] v);
        logic [63:0] s;
        s = (v + 64'd32) >> 6;
        return s[23:0];
    endfunction

    function automatic logic [23:0] ln_entry(input int i, input int Depth);
        logic [63:0] y;
        y = udiv64(64'(i) << 30, 64'(Depth));
        return q30_to_q24(ln1p_q30(y));
    endfunction

    localparam logic [23:0] LN2_Q24 = q30_to_q24(ln1p_q30(64'd1 << 30));

endpackage

### rtl/bce_ctrl.sv
`timescale 1ns / 1ps
// Sequencer for the cross-entropy block: handshake, divider count, log steps.
// Depends on bce_pkg.
module bce_ctrl
    import bce_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_axis_tvalid,
    output logic      s_axis_tready,
    input  bce_stat_t stat,
    output bce_cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_DIV  = 4'b0100,
        S_FIN  = 4'b1000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic [4:0] lcnt;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign lcnt          = (cnt_reg >= 5'd5) ? cnt_reg - 5'd5 : cnt_reg;

    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg;
        cmd          = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    cmd.start  = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP:
            begin
                cmd.prep   = 1'b1;
                cnt_next   = '0;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                // log evaluations for p then 1-p ride along the divider
                cmd.div_step = 1'b1;
                cmd.lq       = (cnt_reg >= 5'd5);
                if (cnt_reg < 5'd10)
                begin
                    cmd.l1 = (lcnt == 5'd0);
                    cmd.l2 = (lcnt == 5'd1);
                    cmd.l3 = (lcnt == 5'd2);
                    cmd.l4 = (lcnt == 5'd3);
                    cmd.l5 = (lcnt == 5'd4);
                end
                cnt_next = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                if (stat.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

`ifndef SYNTHESIS
    a_start_to_prep: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.start |=> (state_reg == S_PREP))
        else $error("accepted request did not advance to prep");
    a_div_seeded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PREP) |=> (state_reg == S_DIV && cnt_reg == 5'd0))
        else $error("divider count not cleared on entry");
    a_finish_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |-> stat.out_free)
        else $error("output register overwritten while occupied");
`endif

endmodule

### rtl/bce_dp.sv
`timescale 1ns / 1ps
// Datapath: clamps, radix-2 divider, table log unit, loss accumulator, output
// register. Depends on bce_pkg.
module bce_dp
    import bce_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  bce_cmd_t    cmd,
    output bce_stat_t   stat,
    input  logic [39:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,
    output logic [1:0]  m_axis_tuser
);

    localparam int IDXW = $clog2(LOG_TABLE_DEPTH);
    localparam int POSW = 15 + $clog2(LOG_TABLE_DEPTH + 1);

    // constant ln(1+i/D) table
    logic [23:0] tab [LOG_TABLE_DEPTH];
    for (genvar gi = 0; gi < LOG_TABLE_DEPTH; gi++)
    begin : g_tab
        localparam logic [23:0] V = ln_entry(gi, LOG_TABLE_DEPTH);
        assign tab[gi] = V;
    end

    logic [16:0] t_in, p_in;
    logic [16:0] t_reg;
    logic [15:0] p_reg, q_reg;
    logic        last_reg, clamp_reg;
    logic        pos_reg;
    logic [16:0] num_reg;
    logic [31:0] den_reg;
    logic [32:0] rem_reg;
    logic [31:0] quot_reg;

    assign t_in = s_axis_tdata[16:0];
    assign p_in = s_axis_tdata[33:17];

    // log unit registers
    logic [3:0]      e_reg;
    logic [IDXW-1:0] idx_reg;
    logic [14:0]     r_reg;
    logic [23:0]     a_reg, d_reg;
    logic [38:0]     prod_reg;
    logic [28:0]     nl_reg;
    logic [46:0]     el_reg;

    logic [47:0] sum_reg;
    logic        sat_reg;
    logic        m_valid_reg;
    logic [31:0] m_grad_reg;
    logic [47:0] m_loss_reg;
    logic [1:0]  m_user_reg;

    // log step 1: normalise
    logic [15:0]     lx, lm;
    logic [3:0]      le;
    logic [POSW-1:0] lpos;
    always_comb
    begin
        lx = cmd.lq ? q_reg : p_reg;
        le = '0;
        for (int k = 1; k < 16; k++)
        begin
            if (lx[k])
            begin
                le = 4'(k);
            end
        end
        lm   = lx << (4'd15 - le);
        lpos = POSW'(lm[14:0]) * POSW'(LOG_TABLE_DEPTH);
    end

    // log step 2: table read
    logic [IDXW:0] idx_p1;
    logic [23:0]   ta, tb;
    always_comb
    begin
        idx_p1 = {1'b0, idx_reg} + 1'b1;
        ta     = tab[idx_reg];
        tb     = (idx_p1 == (IDXW+1)'(LOG_TABLE_DEPTH)) ? LN2_Q24 : tab[idx_p1[IDXW-1:0]];
        if (tb < ta)
        begin
            tb = ta;
        end
    end

    // log step 4: combine
    logic [23:0] lnm;
    logic [28:0] whole;
    assign lnm   = a_reg + prod_reg[38:15];
    assign whole = 29'({1'b0, 4'd0} + (5'd16 - {1'b0, e_reg})) * 29'(LN2_Q24);

    // log step 5: weight
    logic [16:0] wt;
    logic [46:0] term;
    assign wt   = cmd.lq ? (ONE_Q16 - t_reg) : t_reg;
    assign term = 47'(wt) * 47'(nl_reg);

    // divider step
    logic [33:0] rem2;
    assign rem2 = {rem_reg, 1'b0};

    // finish: saturate gradient, accumulate loss
    logic        ovf, gsat, lsat, sat_new;
    logic [31:0] grad;
    logic [46:0] elr_full;
    logic [22:0] elr;
    logic [48:0] sum_add;
    logic [47:0] sum_new;
    always_comb
    begin
        ovf = (num_reg >= 17'(den_reg)) && (den_reg[31:17] == '0);
        if (pos_reg)
        begin
            gsat = ovf || (quot_reg > 32'h7FFF_FFFF);
            grad = gsat ? 32'h7FFF_FFFF : quot_reg;
        end
        else
        begin
            gsat = ovf || (quot_reg > 32'h8000_0000);
            grad = gsat ? 32'h8000_0000 : (32'd0 - quot_reg);
        end
        elr_full = el_reg + 47'(24'h80_0000);
        elr      = elr_full[46:24];
        sum_add  = {1'b0, sum_reg} + 49'(elr);
        lsat     = sum_add[48];
        sum_new  = lsat ? SUM_MAX : sum_add[47:0];
        sat_new  = sat_reg | clamp_reg | gsat | lsat;
    end

    assign stat.out_free = !m_valid_reg || m_axis_tready;

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            t_reg     <= (t_in > ONE_Q16) ? ONE_Q16 : t_in;
            p_reg     <= (p_in == '0) ? 16'd1 : (p_in >= ONE_Q16) ? 16'hFFFF : p_in[15:0];
            q_reg     <= (p_in == '0) ? 16'hFFFF : (p_in >= ONE_Q16) ? 16'd1
                                      : 16'(ONE_Q16 - p_in);
            clamp_reg <= (t_in > ONE_Q16) || (p_in == '0) || (p_in >= ONE_Q16);
            last_reg  <= s_axis_tlast;
        end
        if (cmd.prep)
        begin
            pos_reg  <= ({1'b0, p_reg} >= t_reg);
            num_reg  <= ({1'b0, p_reg} >= t_reg) ? {1'b0, p_reg} - t_reg
                                                 : t_reg - {1'b0, p_reg};
            rem_reg  <= ({1'b0, p_reg} >= t_reg) ? 33'({1'b0, p_reg} - t_reg)
                                                 : 33'(t_reg - {1'b0, p_reg});
            den_reg  <= p_reg * q_reg;
            quot_reg <= '0;
        end
        if (cmd.div_step)
        begin
            if (rem2 >= {2'b0, den_reg})
            begin
                rem_reg  <= 33'(rem2 - {2'b0, den_reg});
                quot_reg <= {quot_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem2[32:0];
                quot_reg <= {quot_reg[30:0], 1'b0};
            end
        end
        if (cmd.l1)
        begin
            e_reg   <= le;
            idx_reg <= lpos[15+IDXW-1:15];
            r_reg   <= lpos[14:0];
        end
        if (cmd.l2)
        begin
            a_reg <= ta;
            d_reg <= tb - ta;
        end
        if (cmd.l3)
        begin
            prod_reg <= 39'(d_reg) * 39'(r_reg);
        end
        if (cmd.l4)
        begin
            nl_reg <= (whole > 29'(lnm)) ? whole - 29'(lnm) : '0;
        end
        if (cmd.l5)
        begin
            el_reg <= cmd.lq ? el_reg + term : term;
        end
        if (cmd.finish)
        begin
            m_grad_reg <= grad;
            m_loss_reg <= last_reg ? {1'b0, sum_new[47:1]} : '0;
            m_user_reg <= {sat_new, last_reg};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg     <= '0;
            sat_reg     <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish)
            begin
                sum_reg <= last_reg ? '0 : sum_new;
                sat_reg <= last_reg ? 1'b0 : sat_new;
            end
            if (cmd.finish)
            begin
                m_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {m_loss_reg, m_grad_reg};
    assign m_axis_tuser  = m_user_reg;

`ifndef SYNTHESIS
    a_loss_only_last: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tuser[0]) |-> (m_axis_tdata[79:32] == '0))
        else $error("loss shown on a non-final result");
    a_sum_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && last_reg) |=> (sum_reg == '0 && !sat_reg))
        else $error("accumulator not cleared after final element");
    a_ovf_flagged: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.finish && ovf) |=> m_axis_tuser[1])
        else $error("gradient overflow not flagged");
`endif

endmodule

### rtl/binary_cross_entropy_loss_grad.sv
`timescale 1ns / 1ps
// Top level of the binary cross-entropy gradient and loss block.
// Depends on bce_pkg, bce_ctrl and bce_dp.
//
// Takes (target, prediction) pairs in unsigned Q1.16 and returns, for each,
// the gradient (p-t)/(p*(1-p)) in signed Q16.16, truncated toward zero and
// saturated. A running loss -(t*ln p + (1-t)*ln(1-p)) is summed in Q32.16;
// on the request marked tlast the result also carries half that sum and the
// sum and sticky flag are cleared. A prediction of 0 or of one and above is
// clamped to the nearest value inside (0,1), a target above one is clamped
// to one; these, gradient saturation and sum saturation set the sticky flag
// reported in tuser. One request is worked at a time: after acceptance the
// denominator is formed, the radix-2 restoring divider runs with the two
// table-driven log evaluations alongside it, and a finish step loads the
// output register; no new request is taken until that step. The finish step
// holds while the output register is still occupied. The result waits in
// an output register, so a new request is taken while the previous result
// is still pending. The ln(1+x) table is a constant of LOG_TABLE_DEPTH
// entries built at elaboration; there is no clearing pass after reset.
module binary_cross_entropy_loss_grad
    import bce_pkg::*;
#(
    parameter int LOG_TABLE_DEPTH = LOG_TABLE_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [39:0] s_axis_tdata,   // [16:0] target, [33:17] prediction, rest zero
    input  logic        s_axis_tlast,   // last element of the batch
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [79:0] m_axis_tdata,   // [31:0] gradient, [79:32] loss
    output logic [1:0]  m_axis_tuser    // [0] loss_valid, [1] saturated
);

    bce_cmd_t  cmd;
    bce_stat_t stat;

    // sequencer: handshake and step commands
    bce_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .stat          (stat),
        .cmd           (cmd)
    );

    // arithmetic, accumulator and output register
    bce_dp #(
        .LOG_TABLE_DEPTH (LOG_TABLE_DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .stat          (stat),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule
